>>> design/sltd_pkg.sv
package sltd_pkg;

  // Frame layout constants.
  localparam int unsigned HeaderBytes   = 4;
  localparam int unsigned FrameOverhead = 6;
  localparam int unsigned LenCeiling    = 249;

  // Configuration register indices.
  localparam logic [7:0] CFG_FIRST_SYNC  = 8'd0;
  localparam logic [7:0] CFG_SECOND_SYNC = 8'd1;
  localparam logic [7:0] CFG_TAIL        = 8'd2;
  localparam logic [7:0] CFG_MAX_LEN     = 8'd3;

  // Reset values of the configuration registers.
  localparam logic [7:0] RST_FIRST_SYNC  = 8'd170;
  localparam logic [7:0] RST_SECOND_SYNC = 8'd85;
  localparam logic [7:0] RST_TAIL        = 8'd13;
  localparam logic [7:0] RST_MAX_LEN     = 8'd64;

  // Queue depth between the classifier and the frame tracker.
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // One classified byte: the byte itself and its compares against the setup.
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       is_sync1;
    logic       is_sync2;
    logic       is_tail;
    logic       len_ok;
  } class_t;

endpackage

>>> design/sltd_front.sv
module sltd_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic [7:0]         rx_byte_i,
  input  logic               cfg_valid_i,
  input  logic [7:0]         cfg_index_i,
  input  logic [7:0]         cfg_data_i,
  output logic               push_o,
  output sltd_pkg::class_t   entry_o
);
  import sltd_pkg::*;

  logic [7:0] first_sync_q;
  logic [7:0] second_sync_q;
  logic [7:0] tail_q;
  logic [7:0] max_len_q;
  logic [7:0] limit;

  // Configuration registers; writes to unknown indices are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_sync_q  <= RST_FIRST_SYNC;
      second_sync_q <= RST_SECOND_SYNC;
      tail_q        <= RST_TAIL;
      max_len_q     <= RST_MAX_LEN;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_FIRST_SYNC:  first_sync_q  <= cfg_data_i;
        CFG_SECOND_SYNC: second_sync_q <= cfg_data_i;
        CFG_TAIL:        tail_q        <= cfg_data_i;
        CFG_MAX_LEN:     max_len_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The length limit is clamped so that the whole frame size fits in a byte.
  assign limit = (max_len_q > 8'(LenCeiling)) ? 8'(LenCeiling) : max_len_q;

  // Classify the byte against every compare the tracker may need.
  always_comb begin
    entry_o.rx_byte  = rx_byte_i;
    entry_o.is_sync1 = (rx_byte_i == first_sync_q);
    entry_o.is_sync2 = (rx_byte_i == second_sync_q);
    entry_o.is_tail  = (rx_byte_i == tail_q);
    entry_o.len_ok   = (rx_byte_i <= limit);
  end

  assign push_o = in_valid_i;

endmodule

>>> design/sltd_queue.sv
module sltd_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  sltd_pkg::class_t push_data_i,
  output logic             push_ready_o,
  output logic             pop_valid_o,
  input  logic             pop_i,
  output sltd_pkg::class_t pop_data_o
);
  import sltd_pkg::*;

  class_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0]   count_q, count_d;
  logic                   do_push;
  logic                   do_pop;

  assign push_ready_o = (count_q != QueueCntW'(QueueDepth));
  assign pop_valid_o  = (count_q != '0);
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;
  assign pop_data_o   = mem_q[rd_ptr_q];

  // Pointer and fill level updates, wrapping at the queue depth.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage needs no reset; entries are only read once written.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> design/sltd_back.sv
module sltd_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             pop_valid_i,
  input  sltd_pkg::class_t entry_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [7:0]       data_byte_o,
  output logic             captured_o,
  output logic [7:0]       byte_index_o,
  output logic             frame_end_o,
  output logic             tail_ok_o,
  output logic             dropped_o,
  output logic [31:0]      tail_error_count_o
);
  import sltd_pkg::*;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_SYNC2 = 2'd1;
  localparam logic [1:0] PH_HDR   = 2'd2;
  localparam logic [1:0] PH_BODY  = 2'd3;

  logic [1:0]  phase_q, phase_d;
  logic [7:0]  pos_q, pos_d;
  logic [7:0]  exp_len_q, exp_len_d;
  logic [31:0] err_q, err_d;
  logic [7:0]  pos_inc;
  logic        out_valid_q;

  logic        cap, fend, tok, drop;
  logic [7:0]  idx;

  logic [7:0]  data_q, idx_q;
  logic        cap_q, fend_q, tok_q, drop_q;

  // Take a byte whenever the output register is free or being emptied.
  assign pop_o   = pop_valid_i && (!out_valid_q || out_ready_i);
  assign pos_inc = pos_q + 8'd1;

  // Frame tracking for the byte at the head of the queue.
  always_comb begin
    phase_d   = phase_q;
    pos_d     = pos_q;
    exp_len_d = exp_len_q;
    err_d     = err_q;
    cap       = 1'b0;
    idx       = '0;
    fend      = 1'b0;
    tok       = 1'b0;
    drop      = 1'b0;
    case (phase_q)
      PH_IDLE: begin
        if (entry_i.is_sync1) begin
          cap     = 1'b1;
          pos_d   = 8'd1;
          phase_d = PH_SYNC2;
        end
      end
      PH_SYNC2: begin
        cap = 1'b1;
        idx = 8'd1;
        if (entry_i.is_sync2) begin
          pos_d   = 8'd2;
          phase_d = PH_HDR;
        end else begin
          drop      = 1'b1;
          phase_d   = PH_IDLE;
          pos_d     = '0;
          exp_len_d = '0;
        end
      end
      PH_HDR: begin
        cap   = 1'b1;
        idx   = pos_q;
        pos_d = pos_inc;
        if (pos_inc >= 8'(HeaderBytes)) begin
          if (!entry_i.len_ok) begin
            drop      = 1'b1;
            phase_d   = PH_IDLE;
            pos_d     = '0;
            exp_len_d = '0;
          end else begin
            exp_len_d = entry_i.rx_byte + 8'(FrameOverhead);
            phase_d   = PH_BODY;
          end
        end
      end
      default: begin
        cap   = 1'b1;
        idx   = pos_q;
        pos_d = pos_inc;
        if ((pos_inc >= exp_len_q) || (pos_inc == '0)) begin
          fend = 1'b1;
          if (entry_i.is_tail) begin
            tok = 1'b1;
          end else begin
            err_d = err_q + 32'd1;
          end
          phase_d   = PH_IDLE;
          pos_d     = '0;
          exp_len_d = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      pos_q       <= '0;
      exp_len_q   <= '0;
      err_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        phase_q   <= phase_d;
        pos_q     <= pos_d;
        exp_len_q <= exp_len_d;
        err_q     <= err_d;
      end
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output register for the result flags.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      data_q <= entry_i.rx_byte;
      cap_q  <= cap;
      idx_q  <= idx;
      fend_q <= fend;
      tok_q  <= tok;
      drop_q <= drop;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign data_byte_o  = data_q;
  assign captured_o   = cap_q;
  assign byte_index_o = idx_q;
  assign frame_end_o  = fend_q;
  assign tail_ok_o    = tok_q;
  assign dropped_o    = drop_q;
  // The counter only moves when a result is loaded, so it matches the shown result.
  assign tail_error_count_o = err_q;

endmodule

>>> design/sync_length_tail_deframer.sv
// Channel   Direction  Handshake                   Payload
// in        input      in_valid_i / in_ready_o     rx_byte_i
// out       output     out_valid_o / out_ready_i   data_byte_o .. tail_error_count_o
// cfg       input      cfg_valid_i / cfg_ready_o   cfg_index_i, cfg_data_i
//
// One byte per cycle is sustained while the output is not stalled; a byte's result
// reaches the output register once it has passed the two-entry queue.
// The frame tracker updates its state and the output register together.
// Reset is asynchronous and active low, and clears the tracker, the queue and
// the tail error count; the setup registers return to their reset values.
// A stalled output fills the queue, after which in_ready_o drops.
module sync_length_tail_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  data_byte_o,
  output logic        captured_o,
  output logic [7:0]  byte_index_o,
  output logic        frame_end_o,
  output logic        tail_ok_o,
  output logic        dropped_o,
  output logic [31:0] tail_error_count_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);
  import sltd_pkg::*;

  logic   push;
  class_t push_entry;
  logic   pop_valid;
  logic   pop;
  class_t pop_entry;

  assign cfg_ready_o = 1'b1;

  sltd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .rx_byte_i   (rx_byte_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .push_o      (push),
    .entry_o     (push_entry)
  );

  sltd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_entry),
    .push_ready_o (in_ready_o),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .pop_data_o   (pop_entry)
  );

  sltd_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .pop_valid_i        (pop_valid),
    .entry_i            (pop_entry),
    .pop_o              (pop),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .data_byte_o        (data_byte_o),
    .captured_o         (captured_o),
    .byte_index_o       (byte_index_o),
    .frame_end_o        (frame_end_o),
    .tail_ok_o          (tail_ok_o),
    .dropped_o          (dropped_o),
    .tail_error_count_o (tail_error_count_o)
  );

endmodule

>>> design/sltd_checker.sv
module sltd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [7:0]  data_byte_o,
  input logic        captured_o,
  input logic [7:0]  byte_index_o,
  input logic        frame_end_o,
  input logic        tail_ok_o,
  input logic        dropped_o,
  input logic [31:0] tail_error_count_o
);

  // A stalled result holds until its transaction completes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(data_byte_o)
      && $stable(byte_index_o) && $stable(tail_error_count_o))
    else $error("stalled result changed");

  // A matched tail is only reported on the byte that ends a frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && tail_ok_o |-> frame_end_o && captured_o && !dropped_o)
    else $error("tail_ok without frame end");

  // A byte outside any frame carries no position or flags.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !captured_o |-> byte_index_o == 8'd0 && !frame_end_o && !dropped_o)
    else $error("uncaptured byte carries flags");

  // The error count only moves with a newly shown frame end whose tail failed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(tail_error_count_o) |-> out_valid_o && frame_end_o && !tail_ok_o
      && tail_error_count_o == $past(tail_error_count_o) + 32'd1)
    else $error("unexpected tail error count change");

endmodule

bind sync_length_tail_deframer sltd_checker u_sltd_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .out_valid_o        (out_valid_o),
  .out_ready_i        (out_ready_i),
  .data_byte_o        (data_byte_o),
  .captured_o         (captured_o),
  .byte_index_o       (byte_index_o),
  .frame_end_o        (frame_end_o),
  .tail_ok_o          (tail_ok_o),
  .dropped_o          (dropped_o),
  .tail_error_count_o (tail_error_count_o)
);

>>> sim/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sltd_pkg::*;

  // Flags that come back with every byte.
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        captured;
    logic [7:0]  byte_index;
    logic        frame_end;
    logic        tail_ok;
    logic        dropped;
    logic [31:0] tail_errors;
  } byte_flags_t;

  // Frame tracker model and the queue of flags still owed by the block.
  class frame_flag_scoreboard;
    typedef enum logic [1:0] {HUNT, SECOND_SYNC, HEADER, BODY} track_e;

    logic [7:0]  sync1, sync2, tail, max_len;
    track_e      track;
    logic [7:0]  pos, frame_total;
    logic [31:0] tail_errs;
    byte_flags_t flags_due[$];
    int unsigned errors;

    function new();
      sync1     = RST_FIRST_SYNC;
      sync2     = RST_SECOND_SYNC;
      tail      = RST_TAIL;
      max_len   = RST_MAX_LEN;
      tail_errs = '0;
      errors    = 0;
      go_idle();
    endfunction

    function void go_idle();
      track       = HUNT;
      pos         = '0;
      frame_total = '0;
    endfunction

    // Register writes with an unknown index leave the setup alone.
    function void write_reg(logic [7:0] idx, logic [7:0] val);
      case (idx)
        CFG_FIRST_SYNC:  sync1   = val;
        CFG_SECOND_SYNC: sync2   = val;
        CFG_TAIL:        tail    = val;
        CFG_MAX_LEN:     max_len = val;
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return flags_due.size();
    endfunction

    // Work out the flags for one accepted byte and advance the tracker.
    function void predict_flags(logic [7:0] b);
      byte_flags_t f;
      int unsigned lim;
      f = '0;
      f.data_byte = b;
      case (track)
        HUNT: begin
          if (b == sync1) begin
            f.captured = 1'b1;
            pos        = 8'd1;
            track      = SECOND_SYNC;
          end
        end
        SECOND_SYNC: begin
          f.captured   = 1'b1;
          f.byte_index = 8'd1;
          if (b == sync2) begin
            pos   = 8'd2;
            track = HEADER;
          end else begin
            f.dropped = 1'b1;
            go_idle();
          end
        end
        HEADER: begin
          f.captured   = 1'b1;
          f.byte_index = pos;
          pos          = pos + 8'd1;
          if (pos >= HeaderBytes) begin
            lim = (max_len > LenCeiling) ? LenCeiling : max_len;
            if (b > lim) begin
              f.dropped = 1'b1;
              go_idle();
            end else begin
              frame_total = 8'(FrameOverhead + b);
              track       = BODY;
            end
          end
        end
        default: begin
          f.captured   = 1'b1;
          f.byte_index = pos;
          pos          = pos + 8'd1;
          if (pos >= frame_total || pos == 8'd0) begin
            f.frame_end = 1'b1;
            if (b == tail) f.tail_ok = 1'b1;
            else tail_errs = tail_errs + 32'd1;
            go_idle();
          end
        end
      endcase
      f.tail_errors = tail_errs;
      flags_due.push_back(f);
    endfunction

    // One line per mismatch, and every one is counted.
    task report(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    task compare(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) report($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    task check_result(byte_flags_t got);
      byte_flags_t want;
      if (flags_due.size() == 0) begin
        report($sformatf("result for byte %02h with nothing outstanding", got.data_byte));
        return;
      end
      want = flags_due.pop_front();
      compare("data_byte", 32'(got.data_byte), 32'(want.data_byte));
      compare("captured", 32'(got.captured), 32'(want.captured));
      compare("byte_index", 32'(got.byte_index), 32'(want.byte_index));
      compare("frame_end", 32'(got.frame_end), 32'(want.frame_end));
      compare("tail_ok", 32'(got.tail_ok), 32'(want.tail_ok));
      compare("dropped", 32'(got.dropped), 32'(want.dropped));
      compare("tail_error_count", got.tail_errors, want.tail_errors);
    endtask
  endclass

  typedef enum int unsigned {ALWAYS_READY, COIN_FLIP, ONE_IN_FOUR, LONG_HOLDS} stall_e;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic [7:0]  rx_byte_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  data_byte_o;
  logic        captured_o;
  logic [7:0]  byte_index_o;
  logic        frame_end_o;
  logic        tail_ok_o;
  logic        dropped_o;
  logic [31:0] tail_error_count_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_index_i = '0;
  logic [7:0]  cfg_data_i  = '0;

  frame_flag_scoreboard sb = new();

  int unsigned sent       = 0;
  int          burst_left = 4;
  int unsigned rx_cycle   = 0;
  int unsigned rx_hold    = 0;
  logic        rx_level   = 1'b1;
  stall_e      rx_mode    = ALWAYS_READY;

  sync_length_tail_deframer u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .rx_byte_i          (rx_byte_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .data_byte_o        (data_byte_o),
    .captured_o         (captured_o),
    .byte_index_o       (byte_index_o),
    .frame_end_o        (frame_end_o),
    .tail_ok_o          (tail_ok_o),
    .dropped_o          (dropped_o),
    .tail_error_count_o (tail_error_count_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // The receiver draws its stall pattern at random from the four patterns.
  always @(posedge clk_i) begin
    rx_cycle++;
    if (rx_cycle % 97 == 0) rx_mode = stall_e'($urandom_range(0, 3));
    case (rx_mode)
      ALWAYS_READY: out_ready_i <= 1'b1;
      COIN_FLIP:    out_ready_i <= 1'($urandom_range(0, 1));
      ONE_IN_FOUR:  out_ready_i <= (rx_cycle % 4 == 0);
      default: begin
        if (rx_hold == 0) begin
          rx_level = ~rx_level;
          rx_hold  = $urandom_range(1, 8);
        end
        rx_hold--;
        out_ready_i <= rx_level;
      end
    endcase
  end

  // Note accepted bytes before checking results, so no ordering is assumed.
  always @(posedge clk_i) begin : watch
    byte_flags_t seen;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.predict_flags(rx_byte_i);
      if (out_valid_o && out_ready_i) begin
        seen = '{data_byte_o, captured_o, byte_index_o, frame_end_o, tail_ok_o,
                 dropped_o, tail_error_count_o};
        sb.check_result(seen);
      end
    end
  end

  // Send one byte; bursts of random length are separated by random gaps.
  task push_byte(input logic [7:0] b);
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent++;
    burst_left--;
    if (burst_left <= 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                : $urandom_range(1, 10);
    end
  endtask

  task write_reg(input logic [7:0] idx, input logic [7:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    sb.write_reg(idx, val);
    @(posedge clk_i);
  endtask

  // Hold the sender off until every outstanding result has come back. The
  // first edge lets the monitor note a byte taken at the edge just passed.
  task wait_until_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // One frame attempt built from the current setup: good, bad tail, bad second
  // sync, oversized length, cut short, or a run of line noise.
  task send_frame();
    int unsigned kind, lim, len, cut, n;
    logic [7:0]  bytes_q[$];
    kind = $urandom_range(0, 11);
    lim  = (sb.max_len > LenCeiling) ? LenCeiling : sb.max_len;
    if (kind >= 10) begin
      n = $urandom_range(1, 6);
      repeat (n) bytes_q.push_back(8'($urandom));
    end else begin
      if (kind == 8) len = $urandom_range(lim + 1, 255);
      else if ($urandom_range(0, 15) == 0) len = $urandom_range(0, lim);
      else len = $urandom_range(0, (lim < 6) ? lim : 6);
      bytes_q.push_back(sb.sync1);
      bytes_q.push_back((kind == 7) ? sb.sync2 ^ 8'($urandom_range(1, 255)) : sb.sync2);
      bytes_q.push_back(8'($urandom));
      bytes_q.push_back(8'(len));
      repeat (len) bytes_q.push_back(8'($urandom));
      bytes_q.push_back(8'($urandom));
      bytes_q.push_back((kind == 5 || kind == 6) ? sb.tail ^ 8'($urandom_range(1, 255))
                                                 : sb.tail);
      if (kind == 9) begin
        cut     = $urandom_range(1, bytes_q.size() - 1);
        bytes_q = bytes_q[0:cut-1];
      end
    end
    foreach (bytes_q[i]) push_byte(bytes_q[i]);
  endtask

  // Noise, a clean empty frame, a bad tail, an oversized length and a bad
  // second sync that must not restart the search on itself.
  logic [7:0] opening [22] = '{
    8'h00, 8'hFF,
    RST_FIRST_SYNC, RST_SECOND_SYNC, 8'h00, 8'h00, 8'hFF, RST_TAIL,
    RST_FIRST_SYNC, RST_SECOND_SYNC, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'h00,
    RST_FIRST_SYNC, RST_SECOND_SYNC, 8'h01, RST_MAX_LEN + 8'd1,
    RST_FIRST_SYNC, RST_FIRST_SYNC, RST_SECOND_SYNC
  };

  initial begin
    int unsigned goal;
    logic [7:0]  s;
    bit          paused;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (opening[i]) push_byte(opening[i]);

    // Each setup phase after the first starts once every outstanding result is back.
    for (int ph = 0; ph < 7; ph++) begin
      if (ph > 0) begin
        wait_until_drained();
        case (ph)
          1: begin
            write_reg(CFG_FIRST_SYNC, 8'h00);
            write_reg(CFG_SECOND_SYNC, 8'hFF);
            write_reg(CFG_TAIL, 8'hFF);
            write_reg(CFG_MAX_LEN, 8'd0);
          end
          2: begin
            write_reg(CFG_FIRST_SYNC, 8'hFF);
            write_reg(CFG_SECOND_SYNC, 8'h00);
            write_reg(CFG_TAIL, 8'h00);
            write_reg(CFG_MAX_LEN, 8'(LenCeiling));
          end
          3: begin
            s = 8'($urandom);
            write_reg(CFG_FIRST_SYNC, s);
            write_reg(CFG_SECOND_SYNC, s);
            write_reg(CFG_TAIL, 8'($urandom));
            write_reg(CFG_MAX_LEN, 8'hFF);
          end
          4: begin
            write_reg(CFG_TAIL, sb.sync1);
            write_reg(CFG_MAX_LEN, 8'(LenCeiling + 1));
          end
          default: begin
            write_reg(CFG_FIRST_SYNC, 8'($urandom));
            write_reg(CFG_SECOND_SYNC, 8'($urandom));
            write_reg(CFG_TAIL, 8'($urandom));
            write_reg(CFG_MAX_LEN, 8'($urandom));
          end
        endcase
        // An index beyond the register map must be ignored.
        write_reg(8'($urandom_range(4, 255)), 8'($urandom));
      end
      goal   = sent + 170;
      paused = 1'b0;
      while (sent < goal) begin
        if (!paused && sent + 90 >= goal) begin
          wait_until_drained();
          paused = 1'b1;
        end
        send_frame();
      end
    end

    wait_until_drained();
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  // Watchdog for a block that stops answering.
  initial begin
    #1_000_000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule
